@@ src/hrc_pkg.sv @@
// shared types, codes and constants of the heading rotation controller
package hrc_pkg;

	// result status codes
	localparam logic [1:0] STATUS_TURNING  = 2'd0;
	localparam logic [1:0] STATUS_DONE     = 2'd1;
	localparam logic [1:0] STATUS_NO_HEAD  = 2'd2;

	// input operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_START  = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_TURN_SPEED = 3'd0;
	localparam logic [2:0] CFG_TOLERANCE  = 3'd1;
	localparam logic [2:0] CFG_GAIN       = 3'd2;
	localparam logic [2:0] CFG_MIN_MULT   = 3'd3;
	localparam logic [2:0] CFG_MAX_MULT   = 3'd4;

	// configuration reset values
	localparam logic [14:0] RST_TURN_SPEED = 15'd1638;
	localparam logic [12:0] RST_TOLERANCE  = 13'd71;
	localparam logic [15:0] RST_GAIN       = 16'd4096;
	localparam logic [15:0] RST_MIN_MULT   = 16'd3072;
	localparam logic [15:0] RST_MAX_MULT   = 16'd40960;

	// pi scaled by 2^40, pi/2 in 2^-20 rad units
	localparam longint PI_2P40    = 64'sd3454217652358;
	localparam longint HALF_PI_20 = 64'sd1647099;
	localparam int     ATAN_LEN   = 24;

	// cordic arc tangent table, 2^-20 rad units
	function automatic logic [20:0] atan_entry(input logic [4:0] idx);
		logic [20:0] v;
		case (idx)
			5'd0:  v = 21'd823550;
			5'd1:  v = 21'd486170;
			5'd2:  v = 21'd256879;
			5'd3:  v = 21'd130396;
			5'd4:  v = 21'd65451;
			5'd5:  v = 21'd32757;
			5'd6:  v = 21'd16383;
			5'd7:  v = 21'd8192;
			5'd8:  v = 21'd4096;
			5'd9:  v = 21'd2048;
			5'd10: v = 21'd1024;
			5'd11: v = 21'd512;
			5'd12: v = 21'd256;
			5'd13: v = 21'd128;
			5'd14: v = 21'd64;
			5'd15: v = 21'd32;
			5'd16: v = 21'd16;
			5'd17: v = 21'd8;
			5'd18: v = 21'd4;
			5'd19: v = 21'd2;
			5'd20: v = 21'd1;
			5'd21: v = 21'd1;
			default: v = 21'd0;
		endcase
		return v;
	endfunction

endpackage

@@ src/hrc_mul.sv @@
// shared signed multiplier with registered product
module hrc_mul #(
	parameter int A_WIDTH = 17,
	parameter int B_WIDTH = 17
) (
	input  logic                              clk,
	input  logic signed [A_WIDTH-1:0]         a,
	input  logic signed [B_WIDTH-1:0]         b,
	output logic signed [A_WIDTH+B_WIDTH-1:0] product_q
);

	always_ff @(posedge clk) begin
		product_q <= a * b;
	end

endmodule

@@ src/heading_rotation_controller.sv @@
// top level: sequencer and datapath of the heading rotation controller
// An orientation sample runs through the multiplier steps, a prerotation,
// min(CORDIC_STEPS,24) CORDIC iterations and a rounding step; during an
// active turn a control step follows: angle wrapping for each wrapped
// angle and the multiplier steps for the command. A start request runs
// shift-add degree scaling with a reciprocal estimate of the quotient, a
// step that corrects that estimate, a wrap and then a control step; with
// no stored heading it emits the no-heading status directly. Either result
// waits in ST_EMIT while out_stall holds the output register. One multiplier
// is shared by every product and one item is worked on at a time; in_stall
// is high while an item is in work. A finished result waits in the output
// register while the next item is accepted.
module heading_rotation_controller #(
	parameter int ANGLE_WIDTH  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic signed [9:0]  target_degrees,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] rate_command,
	output logic [1:0]         status
);

	localparam int W      = ANGLE_WIDTH;
	localparam int F      = W - 4;
	localparam int WW     = W + 3;
	localparam int CW     = 36;
	localparam int ZW     = 24;
	localparam int SW     = 34;
	localparam int MAW    = (W + 1 > 17) ? W + 1 : 17;
	localparam int PW     = MAW + 17;
	localparam int NSTEPS = (CORDIC_STEPS < hrc_pkg::ATAN_LEN) ? CORDIC_STEPS
		: hrc_pkg::ATAN_LEN;

	localparam longint PI_Q = (hrc_pkg::PI_2P40 + (64'sd1 <<< (39 - F))) >>> (40 - F);
	localparam logic signed [WW-1:0] PI_W     = WW'(PI_Q);
	localparam logic signed [WW-1:0] TWO_PI_W = WW'(2 * PI_Q);

	localparam int TSHL = (F >= 12) ? F - 12 : 0;
	localparam int TSHR = (F < 12) ? 12 - F : 0;
	localparam int TRND = (TSHR > 0) ? (1 << (TSHR - 1)) : 0;
	localparam int ZSHR = (F <= 20) ? 20 - F : 0;
	localparam int ZSHL = (F > 20) ? F - 20 : 0;
	localparam int ZRND = (ZSHR > 0) ? (1 << (ZSHR - 1)) : 0;

	localparam logic [63:0] PI40    = 64'(hrc_pkg::PI_2P40);
	localparam logic [63:0] DEG_K   = 64'd90 + (64'd180 << (39 - F));
	// pi * 2^frac / 180 scaled by 2^16, rounded down
	localparam logic [63:0] DEG_RCP = (PI40 << 16) / (64'd180 << (40 - F));

	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL_XY, ST_MUL_WZ, ST_MUL_YY, ST_MUL_ZZ, ST_SUM_C,
		ST_PREROT, ST_CORDIC, ST_ROUND, ST_DEG_MUL, ST_DEG_DIV, ST_DEG_ADD,
		ST_WRAP, ST_ERR, ST_DELTA, ST_MUL_GAIN, ST_CLAMP, ST_MUL_SPEED,
		ST_RATE, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {WR_TGT, WR_ERR, WR_DELTA} wrap_ctx_t;

	state_t    state_q;
	wrap_ctx_t ctx_q;

	logic [14:0] speed_q;
	logic [12:0] tol_cfg_q;
	logic [15:0] gain_q;
	logic [15:0] min_mult_q;
	logic [15:0] max_mult_q;

	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [SW-1:0] s_q, c_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [4:0] cnt_q;

	logic signed [W-1:0] last_heading_q, target_q, prev_q, acc_q, err_q;
	logic heading_valid_q, turn_active_q, full_q, neg_q;

	logic [9:0]  deg_abs_q;
	logic        deg_neg_q, deg_full_q;
	logic [63:0] mag_q, pi_sh_q, num_q, kacc_q, ksh_q;
	logic [W-1:0] quo_q;
	logic signed [WW-1:0] wrap_q;
	logic [15:0] m_q;

	logic signed [15:0] res_rate_q, rate_q;
	logic [1:0]         res_status_q, status_q;
	logic               out_valid_q;

	logic signed [MAW-1:0] mul_a;
	logic signed [16:0]    mul_b;
	logic signed [PW-1:0]  prod;

	logic signed [WW-1:0]  tol_w;
	logic signed [CW-1:0]  s2, c2, dx, dy;
	logic signed [39:0]    z_ext, z_rnd;
	logic signed [W-1:0]   yaw;
	logic [W-1:0]          err_abs;
	logic [PW-1:0]         m_full, r_full;
	logic [15:0]           m_clamp;
	logic signed [15:0]    rate_sat;
	logic signed [W:0]     acc_sum;
	logic signed [W-1:0]   acc_next;
	logic signed [WW-1:0]  acc_abs;
	logic                  full_done;
	logic [63:0]           mag_next, kacc_next, quo_inc, div_chk;
	logic signed [WW-1:0]  rad;
	logic                  accept;

	assign accept       = in_valid && !in_stall;
	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign rate_command = rate_q;
	assign status       = status_q;

	hrc_mul #(.A_WIDTH(MAW), .B_WIDTH(17)) u_mul (
		.clk       (clk),
		.a         (mul_a),
		.b         (mul_b),
		.product_q (prod)
	);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_XY: begin
				mul_a = MAW'(qx_q);
				mul_b = 17'(qy_q);
			end
			ST_MUL_WZ: begin
				mul_a = MAW'(qw_q);
				mul_b = 17'(qz_q);
			end
			ST_MUL_YY: begin
				mul_a = MAW'(qy_q);
				mul_b = 17'(qy_q);
			end
			ST_MUL_ZZ: begin
				mul_a = MAW'(qz_q);
				mul_b = 17'(qz_q);
			end
			ST_MUL_GAIN: begin
				mul_a = signed'(MAW'(err_abs));
				mul_b = signed'({1'b0, gain_q});
			end
			ST_MUL_SPEED: begin
				mul_a = signed'(MAW'(m_q));
				mul_b = signed'({2'b00, speed_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		// tolerance in the angle format, rounding half up
		if (F >= 12)
			tol_w = signed'(WW'(tol_cfg_q) << TSHL);
		else
			tol_w = signed'((WW'(tol_cfg_q) + WW'(TRND)) >> TSHR);

		s2 = CW'(s_q) <<< 1;
		c2 = (CW'(1) <<< 28) - (CW'(c_q) <<< 1);
		dx = x_q >>> cnt_q;
		dy = y_q >>> cnt_q;

		z_ext = 40'(z_q);
		if (F <= 20)
			z_rnd = (z_ext + 40'(ZRND)) >>> ZSHR;
		else
			z_rnd = z_ext <<< ZSHL;
		if (z_rnd > 40'(PI_Q))
			yaw = W'(PI_Q);
		else if (z_rnd < -40'(PI_Q))
			yaw = W'(-PI_Q);
		else
			yaw = z_rnd[W-1:0];

		err_abs = err_q[W-1] ? W'(-err_q) : W'(err_q);

		m_full = (unsigned'(prod) + (PW'(1) << (F - 1))) >> F;
		if (m_full > PW'(max_mult_q))
			m_clamp = max_mult_q;
		else
			m_clamp = m_full[15:0];
		if (m_clamp < min_mult_q)
			m_clamp = min_mult_q;

		r_full = (unsigned'(prod) + PW'(2048)) >> 12;
		if (neg_q)
			rate_sat = (r_full >= PW'(32768)) ? 16'sh8000 : -signed'(r_full[15:0]);
		else
			rate_sat = (r_full > PW'(32767)) ? 16'sh7fff : signed'(r_full[15:0]);

		// saturating accumulation of the wrapped delta
		acc_sum = (W+1)'(acc_q) + (W+1)'(signed'(wrap_q[W-1:0]));
		if (acc_sum > (W+1)'((1 << (W - 1)) - 1))
			acc_next = {1'b0, {(W-1){1'b1}}};
		else if (acc_sum < -(W+1)'(1 << (W - 1)))
			acc_next = {1'b1, {(W-1){1'b0}}};
		else
			acc_next = acc_sum[W-1:0];
		acc_abs = acc_next[W-1] ? -WW'(acc_next) : WW'(acc_next);
		full_done = acc_abs >= (TWO_PI_W - tol_w);

		mag_next  = mag_q + (deg_abs_q[0] ? pi_sh_q : 64'd0);
		kacc_next = kacc_q + (deg_abs_q[0] ? ksh_q : 64'd0);
		// (estimate + 1) times 180 * 2^(40-frac)
		quo_inc = 64'(quo_q) + 64'd1;
		div_chk = ((quo_inc << 7) + (quo_inc << 5) + (quo_inc << 4) + (quo_inc << 2))
			<< (40 - F);
		rad = deg_neg_q ? -signed'(WW'(quo_q)) : signed'(WW'(quo_q));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= hrc_pkg::RST_TURN_SPEED;
			tol_cfg_q  <= hrc_pkg::RST_TOLERANCE;
			gain_q     <= hrc_pkg::RST_GAIN;
			min_mult_q <= hrc_pkg::RST_MIN_MULT;
			max_mult_q <= hrc_pkg::RST_MAX_MULT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hrc_pkg::CFG_TURN_SPEED: speed_q    <= cfg_data[14:0];
				hrc_pkg::CFG_TOLERANCE:  tol_cfg_q  <= cfg_data[12:0];
				hrc_pkg::CFG_GAIN:       gain_q     <= cfg_data;
				hrc_pkg::CFG_MIN_MULT:   min_mult_q <= cfg_data;
				hrc_pkg::CFG_MAX_MULT:   max_mult_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			ctx_q           <= WR_TGT;
			qx_q            <= '0;
			qy_q            <= '0;
			qz_q            <= '0;
			qw_q            <= '0;
			s_q             <= '0;
			c_q             <= '0;
			x_q             <= '0;
			y_q             <= '0;
			z_q             <= '0;
			cnt_q           <= '0;
			last_heading_q  <= '0;
			target_q        <= '0;
			prev_q          <= '0;
			acc_q           <= '0;
			err_q           <= '0;
			heading_valid_q <= 1'b0;
			turn_active_q   <= 1'b0;
			full_q          <= 1'b0;
			neg_q           <= 1'b0;
			deg_abs_q       <= '0;
			deg_neg_q       <= 1'b0;
			deg_full_q      <= 1'b0;
			mag_q           <= '0;
			pi_sh_q         <= '0;
			num_q           <= '0;
			kacc_q          <= '0;
			ksh_q           <= '0;
			quo_q           <= '0;
			wrap_q          <= '0;
			m_q             <= '0;
			res_rate_q      <= '0;
			res_status_q    <= hrc_pkg::STATUS_TURNING;
			rate_q          <= '0;
			status_q        <= hrc_pkg::STATUS_TURNING;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_EMIT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						qx_q <= quat_x;
						qy_q <= quat_y;
						qz_q <= quat_z;
						qw_q <= quat_w;
						if (operation == hrc_pkg::OP_SAMPLE) begin
							state_q <= ST_MUL_XY;
						end else if (!heading_valid_q) begin
							res_rate_q   <= '0;
							res_status_q <= hrc_pkg::STATUS_NO_HEAD;
							state_q      <= ST_EMIT;
						end else begin
							deg_abs_q  <= target_degrees[9] ? 10'(-target_degrees)
								: 10'(target_degrees);
							deg_neg_q  <= target_degrees[9];
							deg_full_q <= (target_degrees == 10'sd360)
								|| (target_degrees == -10'sd360);
							mag_q      <= '0;
							pi_sh_q    <= PI40;
							kacc_q     <= '0;
							ksh_q      <= DEG_RCP;
							cnt_q      <= '0;
							state_q    <= ST_DEG_MUL;
						end
					end
				end
				ST_MUL_XY: state_q <= ST_MUL_WZ;
				ST_MUL_WZ: begin
					s_q     <= prod[SW-1:0];
					state_q <= ST_MUL_YY;
				end
				ST_MUL_YY: begin
					s_q     <= s_q + prod[SW-1:0];
					state_q <= ST_MUL_ZZ;
				end
				ST_MUL_ZZ: begin
					c_q     <= prod[SW-1:0];
					state_q <= ST_SUM_C;
				end
				ST_SUM_C: begin
					c_q     <= c_q + prod[SW-1:0];
					state_q <= ST_PREROT;
				end
				ST_PREROT: begin
					cnt_q <= '0;
					if (s2 == '0 && c2 == '0) begin
						z_q     <= '0;
						state_q <= ST_ROUND;
					end else begin
						// bring the vector into the right half plane
						if (c2 < 0) begin
							if (s2 >= 0) begin
								x_q <= s2;
								y_q <= -c2;
								z_q <= ZW'(hrc_pkg::HALF_PI_20);
							end else begin
								x_q <= -s2;
								y_q <= c2;
								z_q <= -ZW'(hrc_pkg::HALF_PI_20);
							end
						end else begin
							x_q <= c2;
							y_q <= s2;
							z_q <= '0;
						end
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (y_q > 0) begin
						x_q <= x_q + dy;
						y_q <= y_q - dx;
						z_q <= z_q + ZW'(hrc_pkg::atan_entry(cnt_q));
					end else begin
						x_q <= x_q - dy;
						y_q <= y_q + dx;
						z_q <= z_q - ZW'(hrc_pkg::atan_entry(cnt_q));
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(NSTEPS - 1))
						state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					last_heading_q  <= yaw;
					heading_valid_q <= 1'b1;
					state_q         <= turn_active_q ? ST_ERR : ST_IDLE;
				end
				ST_DEG_MUL: begin
					// shift-add of |deg| times pi and times the reciprocal
					mag_q     <= mag_next;
					kacc_q    <= kacc_next;
					deg_abs_q <= deg_abs_q >> 1;
					pi_sh_q   <= pi_sh_q << 1;
					ksh_q     <= ksh_q << 1;
					cnt_q     <= cnt_q + 5'd1;
					if (cnt_q == 5'd9) begin
						num_q   <= mag_next + DEG_K;
						// estimate is the quotient or one below it
						quo_q   <= W'((kacc_next + 64'd32768) >> 16);
						state_q <= ST_DEG_DIV;
					end
				end
				ST_DEG_DIV: begin
					if (num_q >= div_chk)
						quo_q <= quo_q + W'(1);
					state_q <= ST_DEG_ADD;
				end
				ST_DEG_ADD: begin
					wrap_q  <= WW'(last_heading_q) + rad;
					ctx_q   <= WR_TGT;
					state_q <= ST_WRAP;
				end
				ST_ERR: begin
					wrap_q  <= WW'(target_q) - WW'(last_heading_q);
					ctx_q   <= WR_ERR;
					state_q <= ST_WRAP;
				end
				ST_DELTA: begin
					wrap_q  <= WW'(last_heading_q) - WW'(prev_q);
					ctx_q   <= WR_DELTA;
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					// one 2*pi correction per cycle into (-pi, pi]
					if (wrap_q > PI_W) begin
						wrap_q <= wrap_q - TWO_PI_W;
					end else if (wrap_q <= -PI_W) begin
						wrap_q <= wrap_q + TWO_PI_W;
					end else begin
						unique case (ctx_q)
							WR_TGT: begin
								target_q      <= wrap_q[W-1:0];
								full_q        <= deg_full_q;
								neg_q         <= deg_neg_q;
								prev_q        <= last_heading_q;
								acc_q         <= '0;
								turn_active_q <= 1'b1;
								state_q       <= ST_ERR;
							end
							WR_ERR: begin
								err_q <= wrap_q[W-1:0];
								if (full_q) begin
									state_q <= ST_DELTA;
								end else if (WW'(wrap_q[W-1] ? -wrap_q : wrap_q) <= tol_w) begin
									turn_active_q <= 1'b0;
									res_rate_q    <= '0;
									res_status_q  <= hrc_pkg::STATUS_DONE;
									state_q       <= ST_EMIT;
								end else begin
									state_q <= ST_MUL_GAIN;
								end
							end
							WR_DELTA: begin
								acc_q <= acc_next;
								if (full_done) begin
									turn_active_q <= 1'b0;
									res_rate_q    <= '0;
									res_status_q  <= hrc_pkg::STATUS_DONE;
									state_q       <= ST_EMIT;
								end else begin
									prev_q  <= last_heading_q;
									state_q <= ST_MUL_GAIN;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL_GAIN: state_q <= ST_CLAMP;
				ST_CLAMP: begin
					m_q     <= m_clamp;
					state_q <= ST_MUL_SPEED;
				end
				ST_MUL_SPEED: state_q <= ST_RATE;
				ST_RATE: begin
					res_rate_q   <= rate_sat;
					res_status_q <= hrc_pkg::STATUS_TURNING;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					// wait until the output register is free
					if (!out_valid_q || !out_stall) begin
						rate_q      <= res_rate_q;
						status_q    <= res_status_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a done result always carries a zero command
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == hrc_pkg::STATUS_DONE |-> rate_command == 16'sd0)
		else $error("done result with nonzero rate command");

	// the no-heading error only comes out while no heading is stored
	a_err_no_heading: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && res_status_q == hrc_pkg::STATUS_NO_HEAD |-> !heading_valid_q)
		else $error("heading error while a heading is stored");

	// a finished turn leaves no active turn behind
	a_done_clears_turn: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && res_status_q == hrc_pkg::STATUS_DONE |-> !turn_active_q)
		else $error("turn still active after done");

	// a command is only produced during an active turn
	a_rate_needs_turn: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RATE |-> turn_active_q && heading_valid_q)
		else $error("rate command without active turn");

endmodule
